### rtl/hashed_inverse_cdf_sampler_top_defines.svh
// Assertion macros used by the sampler RTL.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef HASHED_INVERSE_CDF_SAMPLER_TOP_DEFINES_SVH
`define HASHED_INVERSE_CDF_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HICDF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hicdf assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HICDF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hicdf assertion failed");

`endif

### rtl/hicdf_pkg.sv
// Shared types, constants and helper functions of the hashed inverse-CDF sampler.
// No dependencies; every RTL module refers to it by scoped names.
`default_nettype none

package hicdf_pkg;

   // Field widths of the streaming and configuration ports.
   localparam int IDX_W       = 15;
   localparam int VAL_W       = 64;
   localparam int KEY_W       = 32;
   localparam int HASH_W      = 64;
   localparam int LEN_W       = 16;
   localparam int REQ_DATA_W  = 144;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Hash constants.
   localparam logic [31:0] GOLDEN_C = 32'h9e3779b9;
   localparam logic [31:0] MIX_C1   = 32'h85ebca6b;
   localparam logic [31:0] MIX_C2   = 32'hc2b2ae35;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED_LOW     = 2'd0,
      CSR_SEED_HIGH    = 2'd1,
      CSR_TABLE_LENGTH = 2'd2
   } csr_reg_type;

   // One item as it travels down the pipeline.
   typedef struct packed {
      logic              valid;
      logic              sample;
      logic [IDX_W-1:0]  entry_index;
      logic [VAL_W-1:0]  entry_value;
      logic [HASH_W-1:0] hash;
   } item_type;

   // Finalizer xor-shift steps.
   function automatic logic [31:0] xor_shift16(input logic [31:0] v);
      return v ^ (v >> 16);
   endfunction

   function automatic logic [31:0] xor_shift13(input logic [31:0] v);
      return v ^ (v >> 13);
   endfunction

endpackage

`default_nettype wire

### rtl/hicdf_hash.sv
// Eight-stage hash pipeline: key premix and three finalizer rounds into a 64-bit hash.
// Depends on hicdf_pkg; each 32-bit multiplier is followed by a register, and the last stage has none.
`default_nettype none

module hicdf_hash (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire logic                         in_sample,
   input  wire logic [hicdf_pkg::IDX_W-1:0]  in_index,
   input  wire logic [hicdf_pkg::VAL_W-1:0]  in_value,
   input  wire logic [hicdf_pkg::KEY_W-1:0]  key_first,
   input  wire logic [hicdf_pkg::KEY_W-1:0]  key_second,
   input  wire logic [31:0]                  seed_low,
   input  wire logic [31:0]                  seed_high,
   output hicdf_pkg::item_type               out_item
);

   localparam int STAGES = 8;

   hicdf_pkg::item_type item_in;
   hicdf_pkg::item_type item_last_in;
   hicdf_pkg::item_type item_ff [1:STAGES];

   logic [31:0] key1_ff, key2_ff;
   logic [31:0] prod1_ff, prod2_ff;
   logic [31:0] mix2_ff, mix3_ff, mix4_ff, mix5_ff, mix6_ff, mix7_ff;
   logic [31:0] mix2_in, mix3_in, mix4_in, mix5_in, mix6_in, mix7_in;
   logic [31:0] side2_ff, side3_ff, side4_ff, side5_ff;
   logic [31:0] side2_in;
   logic [31:0] high_in, low_in;
   logic [31:0] high6_ff, high7_ff;
   logic [31:0] first_in, second_in;

   // Item entering the pipeline; the hash field is filled at the last stage.
   always_comb begin
      item_in             = '0;
      item_in.valid       = in_valid;
      item_in.sample      = in_sample;
      item_in.entry_index = in_index;
      item_in.entry_value = in_value;
   end

   // Item entering the last stage, with the finished hash attached.
   always_comb begin
      item_last_in      = item_ff[STAGES-1];
      item_last_in.hash = {high7_ff, low_in};
   end

   // Round arithmetic between the stage registers.
   always_comb begin
      first_in  = hicdf_pkg::xor_shift16((prod1_ff + key2_ff) ^ seed_low);
      mix2_in   = first_in * hicdf_pkg::MIX_C1;
      side2_in  = prod2_ff + key1_ff;
      mix3_in   = hicdf_pkg::xor_shift13(mix2_ff) * hicdf_pkg::MIX_C2;
      second_in = hicdf_pkg::xor_shift16(hicdf_pkg::xor_shift16(mix3_ff) ^ seed_high);
      mix4_in   = second_in * hicdf_pkg::MIX_C1;
      mix5_in   = hicdf_pkg::xor_shift13(mix4_ff) * hicdf_pkg::MIX_C2;
      high_in   = hicdf_pkg::xor_shift16(mix5_ff);
      mix6_in   = hicdf_pkg::xor_shift16(side5_ff ^ high_in ^ hicdf_pkg::MIX_C1)
                  * hicdf_pkg::MIX_C1;
      mix7_in   = hicdf_pkg::xor_shift13(mix6_ff) * hicdf_pkg::MIX_C2;
      low_in    = hicdf_pkg::xor_shift16(mix7_ff);
   end

   // Stage registers; the whole pipeline moves together on advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= STAGES; i++) begin
            item_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         item_ff[1] <= item_in;
         key1_ff    <= key_first;
         key2_ff    <= key_second;
         prod1_ff   <= key_first * hicdf_pkg::GOLDEN_C;
         prod2_ff   <= key_second * hicdf_pkg::GOLDEN_C;
         for (int i = 2; i < STAGES; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
         mix2_ff  <= mix2_in;
         side2_ff <= side2_in;
         mix3_ff  <= mix3_in;
         side3_ff <= side2_ff;
         mix4_ff  <= mix4_in;
         side4_ff <= side3_ff;
         mix5_ff  <= mix5_in;
         side5_ff <= side4_ff;
         mix6_ff  <= mix6_in;
         high6_ff <= high_in;
         mix7_ff  <= mix7_in;
         high7_ff <= high6_ff;
         item_ff[STAGES] <= item_last_in;
      end
   end

   assign out_item = item_ff[STAGES];

endmodule

`default_nettype wire

### rtl/hicdf_search_stage.sv
// One level of the threshold search, with its own copy of the threshold table.
// Depends on hicdf_pkg. Load items write the copy as they pass; samples read it.
`default_nettype none

module hicdf_search_stage #(
   parameter int TABLE_DEPTH = 32768,
   parameter bit FIRST       = 1'b0
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire hicdf_pkg::item_type             in_item,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]  in_lo,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0]  in_hi,
   output hicdf_pkg::item_type                  out_item,
   output logic [$clog2(TABLE_DEPTH)-1:0]       out_lo,
   output logic [$clog2(TABLE_DEPTH)-1:0]       out_hi
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [hicdf_pkg::VAL_W-1:0] table_mem [TABLE_DEPTH];

   logic [AW:0]                 bound_sum;
   logic [AW-1:0]               rd_addr;
   logic [AW-1:0]               wr_addr;
   logic                        wr_ok;
   logic [hicdf_pkg::VAL_W-1:0] rdata_ff;

   hicdf_pkg::item_type         item_mid_ff;
   logic [AW-1:0]               lo_mid_ff, hi_mid_ff, addr_mid_ff;

   hicdf_pkg::item_type         item_ff;
   logic [AW-1:0]               lo_ff, hi_ff;
   logic [AW-1:0]               lo_in, hi_in;
   logic                        above;

   // The first level probes the last valid entry, the others the midpoint.
   assign bound_sum = {1'b0, in_lo} + {1'b0, in_hi};
   assign rd_addr   = FIRST ? in_hi : bound_sum[AW:1];

   // Load items beyond the table depth are dropped.
   assign wr_ok   = in_item.valid && !in_item.sample
                    && (32'(in_item.entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr = AW'(in_item.entry_index);

   // Table copy: at most one write and one registered read per cycle, while advance is high.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (wr_ok) begin
            table_mem[wr_addr] <= in_item.entry_value;
         end
         rdata_ff <= table_mem[rd_addr];
      end
   end

   // Bounds and item wait here for the read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_mid_ff.valid <= 1'b0;
      end else if (advance) begin
         item_mid_ff <= in_item;
         lo_mid_ff   <= in_lo;
         hi_mid_ff   <= in_hi;
         addr_mid_ff <= rd_addr;
      end
   end

   // Narrow the interval from the comparison of the probed entry.
   always_comb begin
      above = rdata_ff > item_mid_ff.hash;
      lo_in = lo_mid_ff;
      hi_in = hi_mid_ff;
      if (item_mid_ff.sample) begin
         if (FIRST) begin
            if (!above) begin
               lo_in = hi_mid_ff;
            end
         end else if (lo_mid_ff < hi_mid_ff) begin
            if (above) begin
               hi_in = addr_mid_ff;
            end else begin
               lo_in = AW'(addr_mid_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_mid_ff;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
   end

   assign out_item = item_ff;
   assign out_lo   = lo_ff;
   assign out_hi   = hi_ff;

endmodule

`default_nettype wire

### rtl/hicdf_out_buffer.sv
// Result register with a one-entry skid stage on the response channel.
// Depends on hicdf_pkg and the assertion macros in the defines header.
`default_nettype none

`include "hashed_inverse_cdf_sampler_top_defines.svh"

module hicdf_out_buffer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [hicdf_pkg::IDX_W-1:0]  push_index,
   input  wire logic                         rsp_tready,
   output logic                              rsp_tvalid,
   output logic [hicdf_pkg::IDX_W-1:0]       rsp_index,
   output logic                              skid_full
);

   logic                        out_valid_ff;
   logic [hicdf_pkg::IDX_W-1:0] out_index_ff;
   logic                        skid_valid_ff;
   logic [hicdf_pkg::IDX_W-1:0] skid_index_ff;

   // A result lands in the output register when it is free, else in the skid.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_index_ff  <= skid_index_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
            out_index_ff <= push_index;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
         skid_index_ff <= push_index;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_index  = out_index_ff;
   assign skid_full  = skid_valid_ff;

   `HICDF_ASSERT_NOW(a_skid_behind_output, skid_valid_ff, out_valid_ff)
   `HICDF_ASSERT_NEXT(a_stall_fills_skid, out_valid_ff && !rsp_tready && push, skid_valid_ff)
   `HICDF_ASSERT_NEXT(a_skid_drains, rsp_tready && skid_valid_ff, out_valid_ff && !skid_valid_ff)

endmodule

`default_nettype wire

### rtl/hashed_inverse_cdf_sampler_top.sv
// Top level of the hashed inverse-CDF sampler: configuration registers, hash pipeline,
// search levels and response buffer. Depends on hicdf_pkg and the hicdf_* modules.
`default_nettype none

// The sampler accepts one transfer per clock unless stalled: a load item (tuser 0) writes
// a 64-bit threshold, a sample item (tuser 1) hashes its two keys with the seed and
// returns the first table index whose threshold exceeds the hash, or the last valid
// index. The path from request to response runs through eight hash stages, then through
// each search level (the registered table read and the registered compare), then the
// result register. Every search level holds its own full copy of the table, so memory
// is ($clog2(TABLE_DEPTH)+1)*TABLE_DEPTH 64-bit words; a load item updates each copy as
// it passes, which keeps loads and samples in request order. Load items produce no
// response. Seeds and table length may be written only while no transfer is in flight.
// Requests stall only when a finished result and a skid entry are both waiting on the
// response channel.
module hashed_inverse_cdf_sampler_top #(
   parameter int TABLE_DEPTH = 32768
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata, low bit up: entry_index[14:0], entry_value[63:0], key_first[31:0],
   // key_second[31:0], one zero pad bit.
   input  wire logic [hicdf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: action (0 load entry, 1 sample).
   input  wire logic                                req_tuser,
   // Response channel.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata, low bit up: sample_index[14:0], one zero pad bit.
   output logic [hicdf_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // Configuration write port.
   input  wire logic                                csr_wr_en,
   input  wire logic [hicdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hicdf_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int LEVELS = AW + 1;

   logic [31:0]                  seed_low_ff, seed_high_ff;
   logic [hicdf_pkg::LEN_W-1:0]  table_length_ff;

   logic                         advance;
   logic                         skid_full;
   logic [31:0]                  length_wide;
   logic [AW-1:0]                last_index;

   hicdf_pkg::item_type          level_item [LEVELS+1];
   logic [AW-1:0]                level_lo   [LEVELS+1];
   logic [AW-1:0]                level_hi   [LEVELS+1];

   logic                         push;
   logic [hicdf_pkg::IDX_W-1:0]  push_index;
   logic [hicdf_pkg::IDX_W-1:0]  rsp_index;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_low_ff     <= '0;
         seed_high_ff    <= '0;
         table_length_ff <= hicdf_pkg::LEN_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hicdf_pkg::CSR_SEED_LOW:     seed_low_ff     <= csr_wr_data;
            hicdf_pkg::CSR_SEED_HIGH:    seed_high_ff    <= csr_wr_data;
            hicdf_pkg::CSR_TABLE_LENGTH: table_length_ff <= csr_wr_data[hicdf_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Last valid index, with the length clamped to one through the table depth.
   always_comb begin
      length_wide = 32'(table_length_ff);
      if (length_wide == 32'd0) begin
         last_index = '0;
      end else if (length_wide > 32'(TABLE_DEPTH)) begin
         last_index = AW'(TABLE_DEPTH - 1);
      end else begin
         last_index = AW'(length_wide - 32'd1);
      end
   end

   // The pipeline moves as one while the skid entry is free.
   assign advance    = !skid_full;
   assign req_tready = advance;

   hicdf_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_sample  (req_tuser),
      .in_index   (req_tdata[14:0]),
      .in_value   (req_tdata[78:15]),
      .key_first  (req_tdata[110:79]),
      .key_second (req_tdata[142:111]),
      .seed_low   (seed_low_ff),
      .seed_high  (seed_high_ff),
      .out_item   (level_item[0])
   );

   // The search starts over the whole valid range.
   assign level_lo[0] = '0;
   assign level_hi[0] = last_index;

   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      hicdf_search_stage #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .FIRST       (g == 0)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_item  (level_item[g]),
         .in_lo    (level_lo[g]),
         .in_hi    (level_hi[g]),
         .out_item (level_item[g+1]),
         .out_lo   (level_lo[g+1]),
         .out_hi   (level_hi[g+1])
      );
   end

   // Only sample items leave a result.
   assign push       = advance && level_item[LEVELS].valid && level_item[LEVELS].sample;
   assign push_index = hicdf_pkg::IDX_W'(level_lo[LEVELS]);

   hicdf_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_index (push_index),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_index  (rsp_index),
      .skid_full  (skid_full)
   );

   assign rsp_tdata = {1'b0, rsp_index};

endmodule

`default_nettype wire

### tb/hashed_inverse_cdf_sampler_top_test.sv
// Self-checking testbench for the hashed inverse-CDF sampler top level.
// Depends on hicdf_pkg and hashed_inverse_cdf_sampler_top; it predicts every index itself.
module hashed_inverse_cdf_sampler_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH = 32768;
   // Extra settling time covers the pipeline depth; loads give no response.
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam hicdf_pkg::csr_reg_type CSR_SPARE = hicdf_pkg::csr_reg_type'(2'd3);

   // Request tdata layout, lowest field last.
   typedef struct packed {
      logic                         pad;
      logic [hicdf_pkg::KEY_W-1:0]  key_second;
      logic [hicdf_pkg::KEY_W-1:0]  key_first;
      logic [hicdf_pkg::VAL_W-1:0]  entry_value;
      logic [hicdf_pkg::IDX_W-1:0]  entry_index;
   } request_word_type;

   typedef struct {
      bit               sample;
      request_word_type word;
   } request_item_type;

   // How thresholds are laid out in one phase.
   typedef enum {SHAPE_FULL, SHAPE_HALF, SHAPE_PAIRS, SHAPE_SCRAMBLED} table_shape_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [hicdf_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [hicdf_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                              csr_wr_en = 1'b0;
   logic [hicdf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [hicdf_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Predictor state: its own copy of the table and the registers.
   bit [63:0]   model_thresholds [DEPTH];
   bit [31:0]   model_seed_low = '0;
   bit [31:0]   model_seed_high = '0;
   bit [15:0]   model_length = 16'd1;

   request_item_type request_backlog[$];
   bit [14:0]        pending_indexes[$];

   int unsigned queued_total = 0;
   int unsigned accepted_total = 0;
   int unsigned loads_total = 0;
   int unsigned samples_total = 0;
   int unsigned results_total = 0;
   int unsigned settings_total = 0;
   int unsigned highest_index = 0;
   int unsigned error_count = 0;

   int unsigned req_wait = 0;
   bit          req_steady = 1'b0;
   int unsigned rsp_wait = 0;
   bit          rsp_steady = 1'b0;

   hashed_inverse_cdf_sampler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // One line per mismatch.
   task automatic flag_error(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // A length of zero behaves as one, anything past the depth as the depth.
   function automatic int unsigned clamp_length(input bit [15:0] word);
      int unsigned n;
      n = 32'(word);
      if (n < 1) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   // One murmur3-style 32-bit finalizer round.
   function automatic bit [31:0] avalanche32(input bit [31:0] v);
      bit [31:0] h;
      h = v ^ (v >> 16);
      h = h * hicdf_pkg::MIX_C1;
      h = h ^ (h >> 13);
      h = h * hicdf_pkg::MIX_C2;
      return h ^ (h >> 16);
   endfunction

   // 64-bit record hash from the two keys and the current seed.
   function automatic bit [63:0] record_hash(input bit [31:0] k1, input bit [31:0] k2);
      bit [31:0] mixed;
      bit [31:0] upper;
      bit [31:0] lower;
      mixed = k1 * hicdf_pkg::GOLDEN_C + k2;
      upper = avalanche32(avalanche32(mixed ^ model_seed_low) ^ model_seed_high);
      mixed = k2 * hicdf_pkg::GOLDEN_C + k1;
      lower = avalanche32(mixed ^ upper ^ hicdf_pkg::MIX_C1);
      return {upper, lower};
   endfunction

   // Bisection over the valid entries: the last entry is tested first, then the
   // interval [lo,hi] shrinks toward the first threshold above the hash.
   function automatic bit [14:0] pick_index(input bit [63:0] u);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = clamp_length(model_length) - 1;
      if (model_thresholds[hi] <= u) return hi[14:0];
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (model_thresholds[mid] > u) hi = mid;
         else lo = mid + 1;
      end
      return lo[14:0];
   endfunction

   // Threshold for entry idx of an n-entry table. Sorted shapes give each entry, or each
   // pair, its own bucket, so overwrites with fresh jitter leave the table nondecreasing.
   function automatic bit [63:0] threshold_for(input table_shape_type shape,
                                                input int unsigned idx,
                                                input int unsigned n);
      bit [63:0] jitter;
      bit [63:0] span;
      bit [63:0] step;
      jitter = {$urandom, $urandom};
      if (shape == SHAPE_SCRAMBLED) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return jitter;
         endcase
      end
      span = (shape == SHAPE_HALF) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
      step = span / n;
      if (shape == SHAPE_PAIRS) return step * (idx & ~32'd1);
      return step * idx + jitter % step;
   endfunction

   // Keys are mostly random, with the all-zero and all-one words mixed in.
   function automatic bit [31:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Unused fields of each item, but the pad bit, carry random noise.
   function automatic request_item_type make_sample(input bit [31:0] k1, input bit [31:0] k2);
      request_item_type it;
      it.sample = 1'b1;
      it.word.pad = 1'b0;
      it.word.key_first = k1;
      it.word.key_second = k2;
      it.word.entry_value = {$urandom, $urandom};
      it.word.entry_index = 15'($urandom);
      return it;
   endfunction

   function automatic request_item_type make_load(input bit [14:0] idx, input bit [63:0] value);
      request_item_type it;
      it.sample = 1'b0;
      it.word.pad = 1'b0;
      it.word.key_first = $urandom;
      it.word.key_second = $urandom;
      it.word.entry_value = value;
      it.word.entry_index = idx;
      return it;
   endfunction

   task automatic queue_item(input request_item_type it);
      request_backlog.push_back(it);
      queued_total++;
   endtask

   // Hold off until every queued transfer is in, every result is back and the
   // pipeline has had time to retire trailing loads.
   task automatic settle();
      while (accepted_total != queued_total || pending_indexes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all registers back to back, plus the unused index.
   task automatic program_registers(input bit [31:0] slo, input bit [31:0] shi,
                                    input bit [31:0] len_word);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= hicdf_pkg::CSR_SEED_LOW;
      csr_wr_data <= slo;
      @(posedge clock);
      csr_index <= hicdf_pkg::CSR_SEED_HIGH;
      csr_wr_data <= shi;
      @(posedge clock);
      csr_index <= hicdf_pkg::CSR_TABLE_LENGTH;
      csr_wr_data <= len_word;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wr_data <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_total++;
   endtask

   // One register setting: rewrite every valid entry, then random traffic.
   task automatic run_phase(input bit [31:0] slo, input bit [31:0] shi, input bit [31:0] len_word,
                            input table_shape_type shape, input int unsigned count);
      int unsigned n;
      int unsigned idx;
      int unsigned roll;
      settle();
      program_registers(slo, shi, len_word);
      n = clamp_length(len_word[15:0]);
      for (int unsigned i = 0; i < n; i++) begin
         queue_item(make_load(i[14:0], threshold_for(shape, i, n)));
      end
      for (int unsigned k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            queue_item(make_sample(pick_key(), pick_key()));
         end else begin
            idx = (roll < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, DEPTH - 1);
            queue_item(make_load(idx[14:0], threshold_for(shape, idx, n)));
         end
      end
   endtask

   // Length at or past the depth: the last entry is loaded with a zero threshold, the
   // others at random, so every sample stops at the first test and answers the last index.
   task automatic run_wide_phase(input bit [31:0] slo, input bit [31:0] shi,
                                 input bit [31:0] len_word, input int unsigned count);
      int unsigned idx;
      settle();
      program_registers(slo, shi, len_word);
      queue_item(make_load(15'(DEPTH - 1), 64'd0));
      for (int unsigned k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 65) begin
            queue_item(make_sample(pick_key(), pick_key()));
         end else begin
            idx = $urandom_range(0, DEPTH - 2);
            queue_item(make_load(idx[14:0], {$urandom, $urandom}));
         end
      end
   endtask

   // Request driver: a random gap before each transfer, with gap-free stretches.
   always @(posedge clock) begin : drive_requests
      request_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            nxt = request_backlog.pop_front();
            req_tuser <= nxt.sample;
            req_tdata <= nxt.word;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 15) == 0) req_steady = !req_steady;
            req_wait = req_steady ? 0 : $urandom_range(0, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: a random stall after each transfer, with stall-free stretches.
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
            rsp_wait = rsp_steady ? 0 : $urandom_range(0, 6);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: tracks register writes, predicts each sample and checks each result.
   always @(posedge clock) begin : observe
      request_word_type seen;
      logic [14:0]      got;
      bit [14:0]        want;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               hicdf_pkg::CSR_SEED_LOW:     model_seed_low = csr_wr_data;
               hicdf_pkg::CSR_SEED_HIGH:    model_seed_high = csr_wr_data;
               hicdf_pkg::CSR_TABLE_LENGTH: model_length = csr_wr_data[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            seen = req_tdata;
            accepted_total++;
            if (req_tuser) begin
               samples_total++;
               pending_indexes.push_back(
                  pick_index(record_hash(seen.key_first, seen.key_second)));
            end else begin
               loads_total++;
               model_thresholds[seen.entry_index] = seen.entry_value;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[14:0];
            if (pending_indexes.size() == 0) begin
               flag_error($sformatf("result with no sample outstanding, sample_index %0h", got));
            end else begin
               want = pending_indexes.pop_front();
               results_total++;
               if (got !== want) begin
                  flag_error($sformatf("sample_index %0h, expected %0h", got, want));
               end
               if (want > highest_index) highest_index = want;
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, one-entry table: extreme thresholds, keys and indexes.
      queue_item(make_load(15'd0, 64'd0));
      queue_item(make_sample(32'h0, 32'h0));
      queue_item(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_item(make_load(15'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_item(make_sample(32'h0, 32'hFFFF_FFFF));
      queue_item(make_sample(32'hFFFF_FFFF, 32'h0));
      queue_item(make_load(15'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_item(make_load(15'h7FFF, 64'd0));

      // Four entries, sorted with repeats, then out of order.
      settle();
      program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4);
      queue_item(make_load(15'd0, 64'd0));
      queue_item(make_load(15'd1, 64'd0));
      queue_item(make_load(15'd2, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_item(make_load(15'd3, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_item(make_sample(32'h0, 32'h0));
      queue_item(make_sample(32'hFFFF_FFFF, 32'h1234_5678));
      queue_item(make_sample($urandom, $urandom));
      queue_item(make_load(15'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_item(make_load(15'd1, 64'd0));
      queue_item(make_load(15'd2, 64'hFFFF_FFFF_FFFF_FFFF));
      queue_item(make_load(15'd3, 64'd0));
      queue_item(make_sample(32'h0, 32'h0));
      queue_item(make_sample($urandom, $urandom));
      queue_item(make_sample($urandom, $urandom));

      // Random traffic over a range of settings, including lengths at and past the depth.
      run_phase(32'h0, 32'h0, 32'd0, SHAPE_HALF, 100);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, SHAPE_FULL, 120);
      run_phase($urandom, $urandom, 32'd16, SHAPE_HALF, 150);
      run_phase($urandom, $urandom, 32'd37, SHAPE_SCRAMBLED, 150);
      run_phase(32'h0, 32'hFFFF_FFFF, 32'd5, SHAPE_PAIRS, 120);
      run_phase($urandom, $urandom, 32'd300, SHAPE_FULL, 200);
      run_wide_phase($urandom, $urandom, DEPTH, 150);
      run_wide_phase(32'hFFFF_FFFF, 32'h0, ($urandom & 32'hFFFF_0000) | 32'h0000_FFFF, 150);
      run_phase($urandom, $urandom, 32'd60, SHAPE_SCRAMBLED, 150);

      settle();
      $display("Run covered %0d table loads and %0d sample requests over %0d register settings.",
               loads_total, samples_total, settings_total);
      $display("Checked %0d sampled indexes; the highest index returned was %0d.",
               results_total, highest_index);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, several times the slowest expected run.
   initial begin
      #4_000_000;
      $display("Timeout with %0d results still outstanding.", pending_indexes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
